// ===== rtl/isu_pkg.sv =====
// ----------------------------------------------------------------------------
// isu_pkg: shared types and constants of the insertion sorter
// Key width, default store depth and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package isu_pkg;

    localparam int KEY_W        = 32;
    localparam int MAX_KEYS_DEF = 32;

    // Control word sent to every cell of the row in each cycle.
    typedef struct packed {
        logic                    insert;  // place key into the sorted row
        logic                    drain;   // shift the row one cell toward the head
        logic signed [KEY_W-1:0] key;     // key being inserted
    } t_cell_ctl;

endpackage

// ===== rtl/isu_cell.sv =====
// ----------------------------------------------------------------------------
// isu_cell: one compare-and-shift cell of the sorter row
// Holds one key and its valid bit, takes a key from its left neighbor or the
// broadcast key on insert, and takes its right neighbor's key on drain.
// ----------------------------------------------------------------------------
module isu_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  isu_pkg::t_cell_ctl              i_ctl,
    input  logic signed [isu_pkg::KEY_W-1:0] i_left_key,
    input  logic                            i_left_vld,
    input  logic                            i_left_gt,
    input  logic signed [isu_pkg::KEY_W-1:0] i_right_key,
    input  logic                            i_right_vld,
    output logic signed [isu_pkg::KEY_W-1:0] o_key,
    output logic                            o_vld,
    output logic                            o_gt
);

    logic signed [isu_pkg::KEY_W-1:0] r_key;
    logic                             r_vld;
    logic                             w_first_empty;
    logic                             w_take;

    // Strictly greater, so an equal new key lands behind stored equal keys.
    assign o_gt          = r_vld && (r_key > i_ctl.key);
    assign w_first_empty = !r_vld && i_left_vld;
    assign w_take        = o_gt || w_first_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.drain) begin
            r_vld <= i_right_vld;
        end else if (i_ctl.insert && w_first_empty) begin
            r_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.drain) begin
            r_key <= i_right_key;
        end else if (i_ctl.insert && w_take) begin
            r_key <= i_left_gt ? i_left_key : i_ctl.key;
        end
    end

    assign o_key = r_key;
    assign o_vld = r_vld;

endmodule

// ===== rtl/insertion_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter_unit: streaming insertion sorter for signed 32-bit keys
// A row of compare-and-shift cells keeps the keys of one set in ascending
// order and streams them out, smallest first, once the last key arrives.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            word
//  -------   ---------  -------------------  ----------------------------------
//  input     in         start & !busy        i_key_value, i_last_key
//  result    out        o_valid (one cycle)  o_sorted_key, o_last_out,
//                                            o_overflowed
//
// A key is taken in every cycle while busy is low; every cell compares the
// new key with its own in parallel, so each key is placed as it is taken.
// The word marked last starts a drain: the row shifts toward its head once a
// cycle and emits one result per stored key, busy staying high until the
// last one is shifted out. Results are registered from the head cell as
// the row shifts and cannot be stalled by the receiver. Reset (synchronous,
// active low) empties the row and clears the count and the overflow flag.
module insertion_sorter_unit #(
    parameter int MAX_KEYS = isu_pkg::MAX_KEYS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [isu_pkg::KEY_W-1:0] i_key_value,
    input  logic                             i_last_key,
    output logic                             o_valid,
    output logic signed [isu_pkg::KEY_W-1:0] o_sorted_key,
    output logic                             o_last_out,
    output logic                             o_overflowed
);

    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    // Per-cell outputs of the row.
    logic signed [isu_pkg::KEY_W-1:0] w_key [MAX_KEYS];
    logic                             w_vld [MAX_KEYS];
    logic                             w_gt  [MAX_KEYS];

    isu_pkg::t_cell_ctl w_ctl;

    logic [CNT_W-1:0]                 r_count;
    logic                             r_drop;
    logic                             r_busy;
    logic                             r_out_vld;
    logic signed [isu_pkg::KEY_W-1:0] r_out_key;
    logic                             r_out_last;
    logic                             r_out_ovf;

    logic w_accept;
    logic w_full;

    assign w_accept = start && !r_busy;
    assign w_full   = (r_count == CNT_W'(MAX_KEYS));

    // A full row ignores the key; the drop is remembered for the whole set.
    assign w_ctl.insert = w_accept && !w_full;
    assign w_ctl.drain  = r_busy;
    assign w_ctl.key    = i_key_value;

    // The head cell sees an always-valid, never-greater left neighbor, and
    // the tail cell sees an empty right neighbor, so the row drains to empty.
    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        logic signed [isu_pkg::KEY_W-1:0] w_lkey;
        logic                             w_lvld;
        logic                             w_lgt;
        logic signed [isu_pkg::KEY_W-1:0] w_rkey;
        logic                             w_rvld;

        if (g == 0) begin : g_head
            assign w_lkey = i_key_value;
            assign w_lvld = 1'b1;
            assign w_lgt  = 1'b0;
        end else begin : g_mid_l
            assign w_lkey = w_key[g-1];
            assign w_lvld = w_vld[g-1];
            assign w_lgt  = w_gt[g-1];
        end

        if (g == MAX_KEYS - 1) begin : g_tail
            assign w_rkey = w_key[g];
            assign w_rvld = 1'b0;
        end else begin : g_mid_r
            assign w_rkey = w_key[g+1];
            assign w_rvld = w_vld[g+1];
        end

        isu_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_left_key  (w_lkey),
            .i_left_vld  (w_lvld),
            .i_left_gt   (w_lgt),
            .i_right_key (w_rkey),
            .i_right_vld (w_rvld),
            .o_key       (w_key[g]),
            .o_vld       (w_vld[g]),
            .o_gt        (w_gt[g])
        );
    end

    // Control: count keys while filling, then count down one per emitted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_busy;
            if (r_busy) begin
                r_count <= r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_drop <= 1'b0;
                end
            end else if (w_accept) begin
                if (w_full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
                if (i_last_key) begin
                    r_busy <= 1'b1;
                end
            end
        end
    end

    // Result word taken from the head cell as the row shifts.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_out_key  <= w_key[0];
            r_out_last <= (r_count == CNT_W'(1));
            r_out_ovf  <= r_drop;
        end
    end

    assign busy         = r_busy;
    assign o_valid      = r_out_vld;
    assign o_sorted_key = r_out_key;
    assign o_last_out   = r_out_last;
    assign o_overflowed = r_out_ovf;

endmodule

// ===== bench/tb_insertion_sorter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_insertion_sorter_unit: self-checking bench for the insertion sorter
// Drives sets of signed keys through the command port and predicts the sorted
// drain of each set, including stable order of equal keys and overflow, then
// compares every result word with the prediction.
// ----------------------------------------------------------------------------
module tb_insertion_sorter_unit;

    localparam int DEPTH      = isu_pkg::MAX_KEYS_DEF;
    localparam int KW         = isu_pkg::KEY_W;
    localparam int STALL_MAX  = 1000;   // cycles without any handshake
    localparam int GAP_PCT    = 12;
    localparam int RAND_WORDS = 24;

    typedef struct {
        logic signed [KW-1:0] key;
        logic                 last;
        logic                 ovf;
    } t_sorted_word;

    // Keeps a copy of the sorted row and the queue of result words it owes.
    class sorter_scoreboard;
        logic signed [KW-1:0] held_keys[$];
        bit                   dropped;
        t_sorted_word         pending[$];
        int                   errors;
        int                   checked;
        int                   sets_done;
        int                   overflow_sets;

        function new();
            dropped       = 1'b0;
            errors        = 0;
            checked       = 0;
            sets_done     = 0;
            overflow_sets = 0;
        endfunction

        // An accepted input word: insert after every key less than or equal
        // to it, and on the last word queue up the whole drain.
        function void note_key(logic signed [KW-1:0] key, logic last);
            int           pos;
            int           n;
            t_sorted_word w;
            if (held_keys.size() >= DEPTH) begin
                dropped = 1'b1;
            end else begin
                pos = held_keys.size();
                while (pos > 0 && held_keys[pos-1] > key)
                    pos--;
                held_keys.insert(pos, key);
            end
            if (last) begin
                n = held_keys.size();
                for (int k = 0; k < n; k++) begin
                    w.key  = held_keys[k];
                    w.last = (k == n - 1);
                    w.ovf  = dropped;
                    pending.push_back(w);
                end
                sets_done++;
                if (dropped)
                    overflow_sets++;
                held_keys.delete();
                dropped = 1'b0;
            end
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        function void check_result(logic signed [KW-1:0] key, logic last, logic ovf);
            t_sorted_word w;
            if (pending.size() == 0) begin
                report($sformatf("unexpected word key=%0d last=%0b ovf=%0b", key, last, ovf));
                return;
            end
            w = pending.pop_front();
            checked++;
            if (key !== w.key || last !== w.last || ovf !== w.ovf)
                report($sformatf("expected key=%0d last=%0b ovf=%0b, got key=%0d last=%0b ovf=%0b",
                                 w.key, w.last, w.ovf, key, last, ovf));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [KW-1:0] i_key_value;
    logic                 i_last_key;
    logic                 o_valid;
    logic signed [KW-1:0] o_sorted_key;
    logic                 o_last_out;
    logic                 o_overflowed;

    sorter_scoreboard sb;
    bit               gaps_on;
    int               words_sent;

    insertion_sorter_unit #(
        .MAX_KEYS(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_key_value (i_key_value),
        .i_last_key  (i_last_key),
        .o_valid     (o_valid),
        .o_sorted_key(o_sorted_key),
        .o_last_out  (o_last_out),
        .o_overflowed(o_overflowed)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result words cannot be held off, so each one is checked on the edge
    // that ends its strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_sorted_key, o_last_out, o_overflowed);
    end

    // Mix of extremes, small values that collide often, and full-range keys.
    function automatic logic signed [KW-1:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return {1'b0, {(KW-1){1'b1}}};
            1:       return {1'b1, {(KW-1){1'b0}}};
            2, 3, 4: return $signed($urandom_range(16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Presents one word and holds it until the sorter takes it.
    task automatic send_word(input logic signed [KW-1:0] key, input logic last);
        if (gaps_on) begin
            while ($urandom_range(99) < GAP_PCT) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start       <= 1'b1;
        i_key_value <= key;
        i_last_key  <= last;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.note_key(key, last);
        words_sent++;
    endtask

    task automatic send_set(input int len);
        for (int i = 0; i < len; i++) begin
            // One long idle-free stretch in the middle of the run.
            gaps_on = !(words_sent >= 40 && words_sent < 80);
            send_word(pick_key(), i == len - 1);
        end
    endtask

    // Ends the run when neither side has moved a word for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        while (idle_cycles < STALL_MAX) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_MAX);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int rand_start;
        int len;
        sb          = new();
        gaps_on     = 1'b1;
        words_sent  = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_key_value <= '0;
        i_last_key  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes, duplicates of both extremes and a few small values.
        send_word({1'b0, {(KW-1){1'b1}}}, 1'b0);
        send_word({1'b1, {(KW-1){1'b0}}}, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(1, 1'b0);
        send_word({1'b1, {(KW-1){1'b0}}}, 1'b0);
        send_word(5, 1'b0);
        send_word(5, 1'b0);
        send_word({1'b0, {(KW-1){1'b1}}}, 1'b1);
        // A set of a single key, and a set of equal keys.
        send_word(-1, 1'b1);
        send_word(3, 1'b0);
        send_word(3, 1'b0);
        send_word(3, 1'b1);
        // Keys past a full row are dropped, the last word among them.
        send_set(DEPTH + 1 + $urandom_range(3));
        // A row filled exactly, with no drop.
        send_set(DEPTH);

        // Random sets: mostly short, now and then filling or overflowing.
        rand_start = words_sent;
        while (words_sent - rand_start < RAND_WORDS) begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(DEPTH + 4, DEPTH - 2);
            else
                len = $urandom_range(8, 1);
            send_set(len);
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d expected words never arrived", sb.pending.size()));

        $display("Sent %0d key words in %0d sets (%0d with dropped keys).",
                 words_sent, sb.sets_done, sb.overflow_sets);
        $display("Checked %0d sorted words, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
